// File: hw/rtl/circular_range_add_point_query_tree_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the circular range-add point-query tree
// Concurrent checks clocked on the rising edge, disabled while in reset.
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_RANGE_ADD_POINT_QUERY_TREE_TOP_DEFINES_SVH
`define CIRCULAR_RANGE_ADD_POINT_QUERY_TREE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// prop must hold at every edge out of reset
`define CRT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("crtree assertion failed");
// cond must never be true at an edge out of reset
`define CRT_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("crtree forbidden condition seen");
`else
`define CRT_ASSERT(lbl, clk, rstn, prop)
`define CRT_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/crtree_pkg.sv
// ----------------------------------------------------------------------------
// crtree_pkg
// Shared widths, codes and types of the circular range-add point-query tree.
// ----------------------------------------------------------------------------
package crtree_pkg;

  localparam int unsigned MAX_SECTORS_DEF = 4096;

  localparam int unsigned KIND_W  = 2;
  localparam int unsigned POS_W   = 13;
  localparam int unsigned AMT_W   = 32;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned TOTAL_W = 63;

  localparam int unsigned S_DATA_W = 72;
  localparam int unsigned M_DATA_W = 64;

  localparam logic [POS_W-1:0] ACTIVE_RESET = 13'd4096;

  localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  left;
    logic [POS_W-1:0]  right;
    logic [AMT_W-1:0]  amount;
    logic [POS_W-1:0]  position;
  } item_t;

  typedef struct packed {
    logic re;
    logic we;
  } mem_ctl_t;

endpackage

// File: hw/rtl/crtree_ram.sv
// ----------------------------------------------------------------------------
// crtree_ram
// Single-port tree cell memory, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module crtree_ram #(
  parameter int unsigned DEPTH = crtree_pkg::MAX_SECTORS_DEF + 1,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                          clk_i,
  input  crtree_pkg::mem_ctl_t          ctl_i,
  input  logic [AW-1:0]                 addr_i,
  input  logic [crtree_pkg::SUM_W-1:0]  wdata_i,
  output logic [crtree_pkg::SUM_W-1:0]  rdata_o
);

  logic [crtree_pkg::SUM_W-1:0] mem [DEPTH];
  logic [crtree_pkg::SUM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.we) begin
      mem[addr_i] <= wdata_i;
    end
    if (ctl_i.re) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/crtree_seq.sv
// ----------------------------------------------------------------------------
// crtree_seq
// Tree sequencer: read-modify-write walks for adds, read walks for queries,
// and the clearing sweep, all through the cell memory.
// ----------------------------------------------------------------------------
`include "circular_range_add_point_query_tree_top_defines.svh"

module crtree_seq #(
  parameter int unsigned MAX_SECTORS = crtree_pkg::MAX_SECTORS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic [crtree_pkg::POS_W-1:0]    active_i,
  input  crtree_pkg::item_t               item_i,
  input  logic                            start_i,
  output logic                            ready_o,
  output logic                            res_valid_o,
  output logic [crtree_pkg::TOTAL_W-1:0]  res_total_o,
  input  logic                            res_ready_i
);

  localparam int unsigned AW = $clog2(MAX_SECTORS + 1);
  // wide enough for right+1 and for one step past the limit
  localparam int unsigned CW = ((AW > crtree_pkg::POS_W + 1) ? AW : crtree_pkg::POS_W + 1) + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_QUERY,
    ST_DONE
  } state_e;

  state_e                          state_q;
  logic [CW-1:0]                   idx_q;
  logic [1:0]                      phase_q;
  logic [crtree_pkg::SUM_W-1:0]    delta_q;
  logic [crtree_pkg::SUM_W-1:0]    sum_q;
  logic                            pend_q;
  logic [AW-1:0]                   clr_q;
  logic [crtree_pkg::POS_W-1:0]    left_q;
  logic [crtree_pkg::POS_W-1:0]    right_q;
  logic [crtree_pkg::AMT_W-1:0]    amount_q;

  logic [CW-1:0]                   lim;
  logic [CW-1:0]                   active_ext;
  logic [CW-1:0]                   pos_ext;
  logic [CW-1:0]                   low_bit;
  logic                            in_range;
  logic [crtree_pkg::SUM_W-1:0]    amount_ext;

  crtree_pkg::mem_ctl_t            mem_ctl;
  logic [AW-1:0]                   mem_addr;
  logic [crtree_pkg::SUM_W-1:0]    mem_wdata;
  logic [crtree_pkg::SUM_W-1:0]    mem_rdata;

  assign active_ext = CW'(active_i);
  assign lim        = (active_ext > CW'(MAX_SECTORS)) ? CW'(MAX_SECTORS) : active_ext;
  assign pos_ext    = CW'(item_i.position);
  assign low_bit    = idx_q & (~idx_q + CW'(1));
  assign in_range   = (idx_q != '0) && (idx_q <= lim);
  assign amount_ext = crtree_pkg::SUM_W'(amount_q);

  always_comb begin
    mem_ctl   = '0;
    mem_addr  = idx_q[AW-1:0];
    mem_wdata = mem_rdata + delta_q;
    case (state_q)
      ST_CLEAR: begin
        mem_ctl.we = 1'b1;
        mem_addr   = clr_q;
        mem_wdata  = '0;
      end
      ST_ADD_RD: mem_ctl.re = in_range;
      ST_ADD_WR: mem_ctl.we = 1'b1;
      ST_QUERY:  mem_ctl.re = (idx_q != '0);
      default: ;
    endcase
  end

  crtree_ram #(
    .DEPTH (MAX_SECTORS + 1),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .ctl_i   (mem_ctl),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      clr_q    <= '0;
      idx_q    <= '0;
      phase_q  <= '0;
      pend_q   <= 1'b0;
      delta_q  <= '0;
      sum_q    <= '0;
      left_q   <= '0;
      right_q  <= '0;
      amount_q <= '0;
    end else begin
      case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(MAX_SECTORS)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start_i) begin
            left_q   <= item_i.left;
            right_q  <= item_i.right;
            amount_q <= item_i.amount;
            case (item_i.kind)
              crtree_pkg::KIND_ADD: begin
                idx_q   <= CW'(item_i.left);
                delta_q <= crtree_pkg::SUM_W'(item_i.amount);
                phase_q <= 2'd0;
                state_q <= ST_ADD_RD;
              end
              crtree_pkg::KIND_QUERY: begin
                idx_q   <= (pos_ext > lim) ? lim : pos_ext;
                sum_q   <= '0;
                pend_q  <= 1'b0;
                state_q <= ST_QUERY;
              end
              crtree_pkg::KIND_CLEAR: begin
                clr_q   <= '0;
                state_q <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_ADD_RD: begin
          if (in_range) begin
            state_q <= ST_ADD_WR;
          end else begin
            // advance to the next tree update of this add
            case (phase_q)
              2'd0: begin
                idx_q   <= CW'(right_q) + CW'(1);
                delta_q <= '0 - amount_ext;
                phase_q <= 2'd1;
              end
              2'd1: begin
                if (left_q > right_q) begin
                  idx_q   <= CW'(1);
                  delta_q <= amount_ext;
                  phase_q <= 2'd2;
                end else begin
                  state_q <= ST_IDLE;
                end
              end
              default: state_q <= ST_IDLE;
            endcase
          end
        end
        ST_ADD_WR: begin
          idx_q   <= idx_q + low_bit;
          state_q <= ST_ADD_RD;
        end
        ST_QUERY: begin
          if (pend_q) begin
            sum_q <= sum_q + mem_rdata;
          end
          if (idx_q != '0) begin
            idx_q  <= idx_q - low_bit;
            pend_q <= 1'b1;
          end else begin
            pend_q <= 1'b0;
            if (!pend_q) begin
              state_q <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          // hold the result until the output register has room
          if (res_ready_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign ready_o     = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_total_o = sum_q[crtree_pkg::TOTAL_W-1:0];

  `CRT_ASSERT_NEVER(a_no_read_and_write, clk_i, rst_ni, mem_ctl.re && mem_ctl.we)
  `CRT_ASSERT(a_write_after_read, clk_i, rst_ni, (state_q == ST_ADD_WR) |-> $past(mem_ctl.re))
  `CRT_ASSERT(a_start_leaves_idle, clk_i, rst_ni,
      (start_i && ready_o && (item_i.kind == crtree_pkg::KIND_ADD ||
       item_i.kind == crtree_pkg::KIND_QUERY || item_i.kind == crtree_pkg::KIND_CLEAR))
      |=> !ready_o)

endmodule

// File: hw/rtl/circular_range_add_point_query_tree_top.sv
// ----------------------------------------------------------------------------
// circular_range_add_point_query_tree_top
// Fenwick tree over a ring of positions with circular range adds and point
// queries; cells live in a single-port memory.
// ----------------------------------------------------------------------------
// Usage:
//   Items enter on the s_axis channel, tuser carrying the kind (add, query,
//   clear). Only a query makes a result, sent on m_axis as the low 63 bits of
//   the total. active_sectors must be written on cfg while idle (not enforced).
// Operation (one item at a time, set by the single memory port):
//   add   : per tree update, a read of each visited cell and then its write
//           back, then a step to the next update; at most 3 updates of up to
//           13 cells each.
//   query : one read a cycle, up to 12 reads, then the result is loaded into
//           the output register.
//   clear : a sweep writing zero to every cell, 0 to MAX_SECTORS.
// Reset:  runs the same clearing sweep; s_axis_tready is low until it ends.
//   active_sectors returns to 4096.
// Stall:  a finished result waits in the output register; the next item is
//   accepted meanwhile, and a second query result waits inside the core.
// ----------------------------------------------------------------------------
module circular_range_add_point_query_tree_top #(
  parameter int unsigned MAX_SECTORS = crtree_pkg::MAX_SECTORS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // left[12:0], right[25:13], amount[57:26], position[70:58], zero pad [71]
  input  logic [crtree_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // kind[1:0]
  input  logic [crtree_pkg::KIND_W-1:0]     s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // total[62:0], zero pad [63]
  output logic [crtree_pkg::M_DATA_W-1:0]   m_axis_tdata,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [crtree_pkg::POS_W-1:0]      cfg_data_i
);

  logic [crtree_pkg::POS_W-1:0]   active_q;
  crtree_pkg::item_t              item;
  logic                           seq_ready;
  logic                           res_valid;
  logic [crtree_pkg::TOTAL_W-1:0] res_total;
  logic                           slot_free;
  logic                           out_valid_q;
  logic [crtree_pkg::TOTAL_W-1:0] out_total_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= crtree_pkg::ACTIVE_RESET;
    end else if (cfg_valid_i) begin
      active_q <= cfg_data_i;
    end
  end

  assign item.kind     = s_axis_tuser;
  assign item.left     = s_axis_tdata[12:0];
  assign item.right    = s_axis_tdata[25:13];
  assign item.amount   = s_axis_tdata[57:26];
  assign item.position = s_axis_tdata[70:58];

  assign s_axis_tready = seq_ready;
  assign slot_free     = !out_valid_q || m_axis_tready;

  crtree_seq #(
    .MAX_SECTORS (MAX_SECTORS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .active_i    (active_q),
    .item_i      (item),
    .start_i     (s_axis_tvalid),
    .ready_o     (seq_ready),
    .res_valid_o (res_valid),
    .res_total_o (res_total),
    .res_ready_i (slot_free)
  );

  // output register: load a finished result, drop it once the transaction completes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_total_q <= res_total;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_total_q};

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb: circular range-add point-query tree
// Drives adds, queries, clears and unused kinds on the input stream and
// checks every query total against a Fenwick tree kept in the bench. The
// ring size is changed between phases, stalls come at random on both sides,
// and one long hold-off on the output side backs the block up.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned MAX_SECTORS_DEF = crtree_pkg::MAX_SECTORS_DEF;
  localparam int unsigned KIND_W          = crtree_pkg::KIND_W;
  localparam int unsigned POS_W           = crtree_pkg::POS_W;
  localparam int unsigned AMT_W           = crtree_pkg::AMT_W;
  localparam int unsigned SUM_W           = crtree_pkg::SUM_W;
  localparam int unsigned TOTAL_W         = crtree_pkg::TOTAL_W;
  localparam int unsigned S_DATA_W        = crtree_pkg::S_DATA_W;
  localparam int unsigned M_DATA_W        = crtree_pkg::M_DATA_W;
  localparam logic [POS_W-1:0]  ACTIVE_RESET = crtree_pkg::ACTIVE_RESET;
  localparam logic [KIND_W-1:0] KIND_ADD     = crtree_pkg::KIND_ADD;
  localparam logic [KIND_W-1:0] KIND_QUERY   = crtree_pkg::KIND_QUERY;
  localparam logic [KIND_W-1:0] KIND_CLEAR   = crtree_pkg::KIND_CLEAR;
  typedef crtree_pkg::item_t item_t;

  localparam int unsigned TREE_SIZE     = MAX_SECTORS_DEF;
  localparam int unsigned SETTLE_CYCLES = TREE_SIZE + 200;
  localparam int unsigned CYCLE_LIMIT   = 30_000_000;
  localparam int unsigned HOLD_CYCLES   = 600;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata  = '0;
  logic [KIND_W-1:0]   s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [POS_W-1:0]    cfg_data_i    = '0;

  // bench copy of the tree and its size register
  logic [SUM_W-1:0]    tree_cells [1:TREE_SIZE];
  logic [POS_W-1:0]    ring_size;
  logic [TOTAL_W-1:0]  expected_totals [$];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_request  = 0;
  int unsigned hold_left     = 0;
  int unsigned failures      = 0;
  int unsigned cycle_count   = 0;
  logic [TOTAL_W-1:0] want_total;

  circular_range_add_point_query_tree_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("circular_range_add_point_query_tree_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tree arithmetic
  // ---------------------------------------------------------------------------
  function automatic int unsigned span_in_use();
    return (ring_size > TREE_SIZE) ? TREE_SIZE : int'(ring_size);
  endfunction

  function automatic void cell_add(int unsigned idx, logic [SUM_W-1:0] delta);
    int unsigned lim;
    lim = span_in_use();
    if (idx == 0) return;
    while (idx <= lim) begin
      tree_cells[idx] += delta;
      idx += idx & (~idx + 1);
    end
  endfunction

  function automatic logic [SUM_W-1:0] prefix_total(int unsigned idx);
    logic [SUM_W-1:0] sum;
    int unsigned      lim;
    sum = '0;
    lim = span_in_use();
    if (idx > lim) idx = lim;
    while (idx > 0) begin
      sum += tree_cells[idx];
      idx -= idx & (~idx + 1);
    end
    return sum;
  endfunction

  function automatic void tree_apply_item(item_t it);
    logic [SUM_W-1:0] amt;
    logic [SUM_W-1:0] sum;
    amt = SUM_W'(it.amount);
    case (it.kind)
      KIND_ADD: begin
        cell_add(int'(it.left), amt);
        cell_add(int'(it.right) + 1, '0 - amt);
        // wrapped range: the part from position 1 up
        if (it.left > it.right) cell_add(1, amt);
      end
      KIND_QUERY: begin
        sum = prefix_total(int'(it.position));
        expected_totals = {expected_totals, sum[TOTAL_W-1:0]};
      end
      KIND_CLEAR: begin
        foreach (tree_cells[i]) tree_cells[i] = '0;
      end
      default: ;
    endcase
  endfunction

  function automatic item_t make_item(logic [KIND_W-1:0] k, logic [POS_W-1:0] l,
                                      logic [POS_W-1:0] r, logic [AMT_W-1:0] a,
                                      logic [POS_W-1:0] p);
    item_t it;
    it.kind     = k;
    it.left     = l;
    it.right    = r;
    it.amount   = a;
    it.position = p;
    return it;
  endfunction

  function automatic item_t random_item();
    item_t       it;
    int unsigned roll;
    int unsigned span;
    span = span_in_use();
    if (span == 0) span = TREE_SIZE;
    roll = $urandom_range(999);
    if (roll < 480)      it.kind = KIND_ADD;
    else if (roll < 935) it.kind = KIND_QUERY;
    else if (roll < 945) it.kind = KIND_CLEAR;
    else                 it.kind = KIND_UNUSED;
    it.left     = POS_W'($urandom_range(span, 1));
    it.right    = POS_W'($urandom_range(span, 1));
    it.position = POS_W'($urandom_range(span, 1));
    case ($urandom_range(3))
      0: it.amount = $urandom;
      1: it.amount = AMT_W'($urandom_range(255));
      2: it.amount = '1;
      default: it.amount = {1'b1, 31'($urandom)};
    endcase
    // out-of-ring positions now and then
    if ($urandom_range(99) < 8) begin
      it.left     = POS_W'($urandom_range(8191));
      it.right    = POS_W'($urandom_range(8191));
      it.position = POS_W'($urandom_range(8191));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream drivers and result checking
  // ---------------------------------------------------------------------------
  task automatic send_item(input item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.position, it.amount, it.right, it.left};
    s_axis_tuser  <= it.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    tree_apply_item(it);
  endtask

  task automatic wait_for_drain();
    while (expected_totals.size() != 0) @(posedge clk_i);
  endtask

  // drop valid, collect all totals, then give a clear sweep time to finish
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_for_drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ring_size(input logic [POS_W-1:0] value);
    settle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    ring_size = value;
  endtask

  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_totals.size() == 0) begin
        $display("%0t: unexpected total, expected none, actual %h",
                 $time, m_axis_tdata[TOTAL_W-1:0]);
        failures++;
      end else begin
        want_total = expected_totals.pop_front();
        if (m_axis_tdata[TOTAL_W-1:0] !== want_total) begin
          $display("%0t: total mismatch, expected %h, actual %h",
                   $time, want_total, m_axis_tdata[TOTAL_W-1:0]);
          failures++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    send_idle_pct = 16;
    recv_idle_pct = 55;
    send_item(make_item(KIND_QUERY, 13'd1, 13'd1, 32'd0, 13'd1));
    send_item(make_item(KIND_ADD, 13'd1, 13'd4096, 32'hFFFF_FFFF, 13'd0));
    send_item(make_item(KIND_ADD, 13'd4000, 13'd10, 32'd5, 13'd0));
    // left update skipped, right one kept
    send_item(make_item(KIND_ADD, 13'd0, 13'd7, 32'd3, 13'd0));
    // every update out of the ring
    send_item(make_item(KIND_ADD, 13'd8191, 13'd8191, 32'h8000_0000, 13'd0));
    send_item(make_item(KIND_ADD, 13'd100, 13'd8191, 32'd9, 13'd0));
    send_item(make_item(KIND_UNUSED, 13'd1, 13'd4096, 32'd77, 13'd3));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd0));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd1));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd5));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd150));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd4000));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd4096));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd4097));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd8191));
    send_item(make_item(KIND_CLEAR, 13'd0, 13'd0, 32'd0, 13'd0));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd4096));
    send_item(make_item(KIND_ADD, 13'd1, 13'd1, 32'd1, 13'd0));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd1));
    send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd2));
  endtask

  task automatic test_ring_sizes();
    logic [POS_W-1:0] sizes [6];
    sizes = '{13'd0, 13'd1, 13'd8191, 13'd4095, 13'd4096, 13'd2};
    foreach (sizes[s]) begin
      write_ring_size(sizes[s]);
      send_item(make_item(KIND_ADD, 13'd1, 13'd5, 32'd11, 13'd0));
      send_item(make_item(KIND_ADD, 13'd3, 13'd1, 32'd7, 13'd0));
      send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd0));
      send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd1));
      send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0, 13'd8191));
      repeat (30) send_item(random_item());
    end
  endtask

  task automatic test_output_hold();
    recv_idle_pct = 0;
    send_idle_pct = 0;
    hold_request  = HOLD_CYCLES;
    // keep offering while the output is blocked
    repeat (20) begin
      send_item(make_item(KIND_QUERY, 13'd0, 13'd0, 32'd0,
                          POS_W'($urandom_range(TREE_SIZE, 1))));
      send_item(random_item());
    end
  endtask

  task automatic test_drain_pause();
    send_idle_pct = 16;
    recv_idle_pct = 55;
    repeat (30) send_item(random_item());
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait_for_drain();
    repeat (30) send_item(random_item());
  endtask

  function automatic logic [POS_W-1:0] pick_ring_size();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 8)       return '0;
    else if (roll < 18) return POS_W'($urandom_range(8191, TREE_SIZE + 1));
    else if (roll < 30) return POS_W'(TREE_SIZE);
    else if (roll < 60) return POS_W'($urandom_range(32, 1));
    else                return POS_W'($urandom_range(TREE_SIZE, 1));
  endfunction

  task automatic test_random(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (4) begin
      write_ring_size(pick_ring_size());
      repeat (95) send_item(random_item());
    end
  endtask

  initial begin
    ring_size = ACTIVE_RESET;
    foreach (tree_cells[i]) tree_cells[i] = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_ring_sizes();
    test_output_hold();
    test_drain_pause();
    test_random(16, 55);
    test_random(55, 16);
    test_random(0, 0);
    settle();
    if (failures == 0 && expected_totals.size() == 0) begin
      $display("circular_range_add_point_query_tree_top test passed");
    end else begin
      $display("circular_range_add_point_query_tree_top test failed");
    end
    $finish;
  end

endmodule
